// ----- src/sha256_stream_hasher_top_defines.svh -----
// Assertion macros shared by the SHA-256 stream hasher RTL.
`ifndef SHA256_STREAM_HASHER_TOP_DEFINES_SVH
`define SHA256_STREAM_HASHER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define SHS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define SHS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- src/sha256s_pkg.sv -----
// Types, constants and round functions of the SHA-256 stream hasher.
package sha256s_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROUND,
      ST_FOLD,
      ST_PAD,
      ST_OUT
   } state_type;

   // Eight 32-bit words, index 0 is word a / H0.
   typedef logic [7:0][31:0] word8_type;

   typedef struct packed {
      logic       push;
      logic [7:0] data;
      logic       advance;
   } sched_ctl_type;

   typedef struct packed {
      logic       load;
      logic       step;
      logic [5:0] round;
   } round_ctl_type;

   localparam logic [7:0] PAD_MARK      = 8'h80;
   localparam logic [5:0] LENGTH_OFFSET = 6'd56;
   localparam logic [5:0] LAST_BYTE     = 6'd63;
   localparam logic [5:0] LAST_ROUND    = 6'd63;
   localparam logic [2:0] LAST_INDEX    = 3'd7;

   localparam word8_type IV_WORDS = {
      32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
      32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
   };

   localparam logic [31:0] K_TABLE [0:63] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function automatic logic [31:0] big_sigma0(input logic [31:0] x);
      return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic logic [31:0] big_sigma1(input logic [31:0] x);
      return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

   function automatic logic [31:0] small_sigma0(input logic [31:0] x);
      return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic logic [31:0] small_sigma1(input logic [31:0] x);
      return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

endpackage

// ----- src/sha256s_req_if.sv -----
// Input channel: one message byte word per handshake.
interface sha256s_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       has_byte;
   logic       end_of_message;

   modport source (output valid, data_byte, has_byte, end_of_message, input ready);
   modport sink   (input valid, data_byte, has_byte, end_of_message, output ready);
endinterface

// ----- src/sha256s_rsp_if.sv -----
// Result channel: one digest word per handshake.
interface sha256s_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        last_word;

   modport source (output valid, digest_word, word_index, last_word, input ready);
   modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

// ----- src/sha256s_sched.sv -----
// Block buffer and rolling message schedule as a 16-word shift line.
module sha256s_sched
   import sha256s_pkg::*;
(
   input  logic          clock,
   input  sched_ctl_type ctl,
   output logic [31:0]   wt
);

   logic [511:0] w_ff, w_in;
   logic [31:0]  w0, w1, w9, w14, w_new;

   // word i of the line sits i words below the top
   assign w0  = w_ff[511:480];
   assign w1  = w_ff[479:448];
   assign w9  = w_ff[223:192];
   assign w14 = w_ff[63:32];

   assign w_new = w0 + small_sigma0(w1) + w9 + small_sigma1(w14);
   assign wt    = w0;

   always_comb begin
      w_in = w_ff;
      if (ctl.push) begin
         // shift the byte in big-endian: first byte ends at the top
         w_in = {w_ff[503:0], ctl.data};
      end else if (ctl.advance) begin
         w_in = {w_ff[479:0], w_new};
      end
   end

   always_ff @(posedge clock) begin
      w_ff <= w_in;
   end

endmodule

// ----- src/sha256s_round.sv -----
// Shared compression round unit with the a..h working registers.
module sha256s_round
   import sha256s_pkg::*;
(
   input  logic          clock,
   input  round_ctl_type ctl,
   input  word8_type     init,
   input  logic [31:0]   wt,
   output word8_type     vars
);

   word8_type   v_ff, v_in;
   logic [31:0] t1, t2, ch, mj;

   assign ch = (v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]);
   assign mj = (v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]);
   assign t1 = v_ff[7] + big_sigma1(v_ff[4]) + ch + K_TABLE[ctl.round] + wt;
   assign t2 = big_sigma0(v_ff[0]) + mj;

   always_comb begin
      v_in = v_ff;
      if (ctl.load) begin
         v_in = init;
      end else if (ctl.step) begin
         v_in[7] = v_ff[6];
         v_in[6] = v_ff[5];
         v_in[5] = v_ff[4];
         v_in[4] = v_ff[3] + t1;
         v_in[3] = v_ff[2];
         v_in[2] = v_ff[1];
         v_in[1] = v_ff[0];
         v_in[0] = t1 + t2;
      end
   end

   always_ff @(posedge clock) begin
      v_ff <= v_in;
   end

   assign vars = v_ff;

endmodule

// ----- src/sha256_stream_hasher_top.sv -----
// Top level of the SHA-256 stream hasher: sequencer, hash state and padding.
//
// Usage:
//  - req_chan carries one word per handshake: data_byte with has_byte, and
//    end_of_message to close the message. A word with neither bit is a no-op.
//  - rsp_chan returns eight digest words, word_index 0..7, last_word on 7.
//  - The 64th byte of a block starts the shared round unit: 64 rounds at
//    one per cycle, then the fold into the hash state. req ready is low
//    while the round unit runs.
//  - On end_of_message the sequencer pushes the 0x80 mark, zero bytes up to
//    offset 56 and the 8-byte bit length, one byte per cycle, and compresses
//    each block that it fills (one or two).
//  - Digest words then wait on rsp_chan; a stalled receiver holds the block
//    with rsp valid high and req ready low until all eight words are taken.
//    The hash state then returns to the initial values.
//  - Reset (synchronous, active high) loads the initial hash values, clears
//    the byte and fill counts and returns to idle; the first word can be
//    taken in the cycle after reset drops.
`include "sha256_stream_hasher_top_defines.svh"

module sha256_stream_hasher_top
   import sha256s_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   sha256s_req_if.sink     req_chan,
   sha256s_rsp_if.source   rsp_chan
);

   state_type     state_ff, state_in;
   word8_type     hash_ff, hash_in;
   logic [60:0]   byte_count_ff, byte_count_in;
   logic [5:0]    fill_ff, fill_in;
   logic [5:0]    round_ff, round_in;
   logic [63:0]   len_ff, len_in;
   logic          fin_ff, fin_in;
   logic          pad_first_ff, pad_first_in;
   logic          len_on_ff, len_on_in;
   logic [2:0]    out_idx_ff, out_idx_in;

   logic          req_fire, rsp_fire;
   logic          push_en;
   logic [7:0]    push_data;
   logic [7:0]    pad_byte;
   logic          pad_len_byte;
   logic          block_full;
   logic [60:0]   count_next;
   logic [31:0]   wt;
   word8_type     vars;
   sched_ctl_type sched_ctl;
   round_ctl_type round_ctl;

   assign req_fire = req_chan.valid && req_chan.ready;
   assign rsp_fire = rsp_chan.valid && rsp_chan.ready;

   // padding byte: mark first, then zeros, length bytes from offset 56 on
   assign pad_len_byte = !pad_first_ff && (len_on_ff || fill_ff == LENGTH_OFFSET);
   assign pad_byte     = pad_first_ff ? PAD_MARK :
                         (pad_len_byte ? len_ff[63:56] : 8'h00);

   assign count_next = req_chan.has_byte ? byte_count_ff + 61'd1 : byte_count_ff;
   assign block_full = push_en && fill_ff == LAST_BYTE;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_chan.has_byte && fill_ff == LAST_BYTE) begin
                  state_in = ST_ROUND;
               end else if (req_chan.end_of_message) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_ROUND: begin
            if (round_ff == LAST_ROUND) begin
               state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            if (!fin_ff) begin
               state_in = ST_IDLE;
            end else if (len_on_ff) begin
               state_in = ST_OUT;
            end else begin
               state_in = ST_PAD;
            end
         end
         ST_PAD: begin
            if (fill_ff == LAST_BYTE) begin
               state_in = ST_ROUND;
            end
         end
         ST_OUT: begin
            if (rsp_fire && out_idx_ff == LAST_INDEX) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // handshake and unit control
   always_comb begin
      req_chan.ready = 1'b0;
      rsp_chan.valid = 1'b0;
      push_en        = 1'b0;
      push_data      = req_chan.data_byte;
      round_ctl      = '{load: 1'b0, step: 1'b0, round: round_ff};
      case (state_ff)
         ST_IDLE: begin
            req_chan.ready = 1'b1;
            push_en        = req_fire && req_chan.has_byte;
         end
         ST_ROUND: round_ctl.step = 1'b1;
         ST_PAD: begin
            push_en   = 1'b1;
            push_data = pad_byte;
         end
         ST_OUT:  rsp_chan.valid = 1'b1;
         default: ;
      endcase
      round_ctl.load = block_full;
      sched_ctl      = '{push: push_en, data: push_data, advance: round_ctl.step};
   end

   assign rsp_chan.digest_word = hash_ff[out_idx_ff];
   assign rsp_chan.word_index  = out_idx_ff;
   assign rsp_chan.last_word   = (out_idx_ff == LAST_INDEX);

   // datapath register updates
   always_comb begin
      hash_in       = hash_ff;
      byte_count_in = byte_count_ff;
      fill_in       = fill_ff;
      round_in      = round_ff;
      len_in        = len_ff;
      fin_in        = fin_ff;
      pad_first_in  = pad_first_ff;
      len_on_in     = len_on_ff;
      out_idx_in    = out_idx_ff;

      if (push_en) begin
         fill_in = fill_ff + 6'd1;
      end
      if (round_ctl.step) begin
         round_in = round_ff + 6'd1;
      end
      if (req_fire) begin
         byte_count_in = count_next;
         if (req_chan.end_of_message) begin
            len_in       = {count_next, 3'b000};
            fin_in       = 1'b1;
            pad_first_in = 1'b1;
         end
      end
      if (state_ff == ST_PAD) begin
         if (pad_first_ff) begin
            pad_first_in = 1'b0;
         end else if (pad_len_byte) begin
            len_in    = {len_ff[55:0], 8'h00};
            len_on_in = 1'b1;
         end
      end
      if (state_ff == ST_FOLD) begin
         for (int i = 0; i < 8; i++) begin
            hash_in[i] = hash_ff[i] + vars[i];
         end
      end
      if (rsp_fire) begin
         out_idx_in = out_idx_ff + 3'd1;
         if (out_idx_ff == LAST_INDEX) begin
            // drop back to the initial values for the next message
            hash_in       = IV_WORDS;
            byte_count_in = '0;
            fin_in        = 1'b0;
            len_on_in     = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         hash_ff       <= IV_WORDS;
         byte_count_ff <= '0;
         fill_ff       <= '0;
         round_ff      <= '0;
         fin_ff        <= 1'b0;
         pad_first_ff  <= 1'b0;
         len_on_ff     <= 1'b0;
         out_idx_ff    <= '0;
      end else begin
         state_ff      <= state_in;
         hash_ff       <= hash_in;
         byte_count_ff <= byte_count_in;
         fill_ff       <= fill_in;
         round_ff      <= round_in;
         fin_ff        <= fin_in;
         pad_first_ff  <= pad_first_in;
         len_on_ff     <= len_on_in;
         out_idx_ff    <= out_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff <= len_in;
   end

   sha256s_sched u_sched (
      .clock (clock),
      .ctl   (sched_ctl),
      .wt    (wt)
   );

   sha256s_round u_round (
      .clock (clock),
      .ctl   (round_ctl),
      .init  (hash_ff),
      .wt    (wt),
      .vars  (vars)
   );

   `SHS_ASSERT_NOW(a_busy_while_out, clock, reset, rsp_chan.valid, !req_chan.ready,
                   "ready high while digest pending")
   `SHS_ASSERT_NOW(a_round_idle, clock, reset, state_ff != ST_ROUND, round_ff == 6'd0,
                   "round count left nonzero")
   `SHS_ASSERT_NOW(a_out_padded, clock, reset, state_ff == ST_OUT,
                   fill_ff == 6'd0 && !pad_first_ff && len_on_ff,
                   "digest shown before padding done")
   `SHS_ASSERT_NEXT(a_reinit, clock, reset, rsp_fire && rsp_chan.last_word,
                    hash_ff == IV_WORDS && byte_count_ff == 61'd0,
                    "hash state not reinitialized")

endmodule
